[rtl/diamond_difference_sweep_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the diamond difference sweep unit
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIAMOND_DIFFERENCE_SWEEP_UNIT_ASSERT_SVH
`define DIAMOND_DIFFERENCE_SWEEP_UNIT_ASSERT_SVH
`ifndef SYNTH
`define DDSU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddsu assertion failed");
`define DDSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddsu assertion failed");
`else
`define DDSU_ASSERT_SAME(lbl, ante, cons)
`define DDSU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/ddsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsu_pkg
// Shared constants and helpers for the diamond difference sweep unit.
// ----------------------------------------------------------------------------
package ddsu_pkg;

    localparam int MAX_ZONES_X_DEF = 64;
    localparam int MAX_ZONES_Y_DEF = 64;
    localparam int MAX_ZONES_Z_DEF = 64;

    localparam int CNT_W      = 11;
    localparam int ZONES_W    = 7;
    localparam int COS_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int COEF_W     = 30;
    localparam int DEN_W      = 33;

    localparam logic [CFG_IDX_W-1:0] REG_ZONES_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZONES_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZONES_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_COS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_COS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_COS   = 3'd5;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    function automatic logic [31:0] sat34(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = S32_MAX;
        else if (v < -34'sh0_8000_0000)
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] coef_cap(input logic [33:0] q);
        logic [COEF_W-1:0] r;
        if (q[33:COEF_W] != '0)
            r = '1;
        else
            r = q[COEF_W-1:0];
        return r;
    endfunction

endpackage

[rtl/ddsu_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsu channel interfaces
// Zone request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ddsu_zone_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] source;
    logic        [30:0] sigma_total;
    logic        [30:0] width_x;
    logic        [30:0] width_y;
    logic        [30:0] width_z;
    logic signed [31:0] inflow_x;
    logic signed [31:0] inflow_y;
    logic signed [31:0] inflow_z;

    modport src (output valid, source, sigma_total, width_x, width_y, width_z,
                 inflow_x, inflow_y, inflow_z, input ready);
    modport snk (input valid, source, sigma_total, width_x, width_y, width_z,
                 inflow_x, inflow_y, inflow_z, output ready);
endinterface

interface ddsu_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] flux;
    logic signed [31:0] outflow_x;
    logic signed [31:0] outflow_y;
    logic signed [31:0] outflow_z;
    logic               at_exit_x;
    logic               at_exit_y;
    logic               at_exit_z;
    logic               sweep_done;

    modport src (output valid, flux, outflow_x, outflow_y, outflow_z,
                 at_exit_x, at_exit_y, at_exit_z, sweep_done, input ready);
    modport snk (input valid, flux, outflow_x, outflow_y, outflow_z,
                 at_exit_x, at_exit_y, at_exit_z, sweep_done, output ready);
endinterface

[rtl/diamond_difference_sweep_unit.sv]
// Sequence from zone request to result valid: a face read, the coefficient
// divide, multiply-accumulate of the x, y and z face terms, a prep step and
// the quotient divide, which is skipped when the quotient would not fit in 32
// bits or the denominator is zero.
// One zone at a time, paced by the bit-serial dividers: a new zone is taken
// only once the last is done, but while the previous result still waits.
// Reset: asynchronous, active low; registers to reset values, cursors and left
// face to zero. Face stores hold no reset and need no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diamond_difference_sweep_unit
// Diamond-difference transport sweep for one direction over a zone grid.
// ----------------------------------------------------------------------------
`include "diamond_difference_sweep_unit_assert.svh"

module diamond_difference_sweep_unit #(
    parameter int MAX_ZONES_X = ddsu_pkg::MAX_ZONES_X_DEF,
    parameter int MAX_ZONES_Y = ddsu_pkg::MAX_ZONES_Y_DEF,
    parameter int MAX_ZONES_Z = ddsu_pkg::MAX_ZONES_Z_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ddsu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddsu_pkg::CFG_DATA_W-1:0] cfg_data,
    ddsu_zone_if.snk                        zone,
    ddsu_result_if.src                      result
);
    localparam int IX_W    = (MAX_ZONES_X > 1) ? $clog2(MAX_ZONES_X) : 1;
    localparam int IY_W    = (MAX_ZONES_Y > 1) ? $clog2(MAX_ZONES_Y) : 1;
    localparam int IZ_W    = (MAX_ZONES_Z > 1) ? $clog2(MAX_ZONES_Z) : 1;
    localparam int PLANE_D = MAX_ZONES_X * MAX_ZONES_Y;
    localparam int PA_W    = (PLANE_D > 1) ? $clog2(PLANE_D) : 1;
    localparam int CNT_W   = ddsu_pkg::CNT_W;
    localparam int COEF_W  = ddsu_pkg::COEF_W;
    localparam int DEN_W   = ddsu_pkg::DEN_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_COEF = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_PREP = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] state_reg;

    logic [ddsu_pkg::ZONES_W-1:0] zones_x_reg, zones_y_reg, zones_z_reg;
    logic [ddsu_pkg::COS_W-1:0]   x_cos_reg, y_cos_reg, z_cos_reg;
    logic [IX_W-1:0] cur_x_reg;
    logic [IY_W-1:0] cur_y_reg;
    logic [IZ_W-1:0] cur_z_reg;
    logic [31:0]     left_reg;

    logic signed [31:0] src_reg;
    logic [30:0]        sig_reg, wx_reg, wy_reg, wz_reg;
    logic signed [31:0] inx_reg, iny_reg, inz_reg;
    logic signed [31:0] fl_reg, ff_reg, fb_reg;
    logic [COEF_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic [DEN_W-1:0]   den_reg;
    logic signed [63:0] acc_reg;
    logic [1:0]         mstep_reg;
    logic [31:0]        psi_reg;

    logic               rv_reg;
    logic [31:0]        r_flux_reg, r_ox_reg, r_oy_reg, r_oz_reg;
    logic               r_ex_reg, r_ey_reg, r_ez_reg, r_done_reg;

    logic zone_acc;
    logic cfg_hit;
    logic load;

    // effective counts and exit flags
    logic [CNT_W-1:0] nx, ny, nz;
    logic             ex, ey, ez;

    always_comb
    begin
        nx = (zones_x_reg == '0) ? CNT_W'(1) :
             ((CNT_W'(zones_x_reg) > CNT_W'(MAX_ZONES_X)) ? CNT_W'(MAX_ZONES_X)
                                                          : CNT_W'(zones_x_reg));
        ny = (zones_y_reg == '0) ? CNT_W'(1) :
             ((CNT_W'(zones_y_reg) > CNT_W'(MAX_ZONES_Y)) ? CNT_W'(MAX_ZONES_Y)
                                                          : CNT_W'(zones_y_reg));
        nz = (zones_z_reg == '0) ? CNT_W'(1) :
             ((CNT_W'(zones_z_reg) > CNT_W'(MAX_ZONES_Z)) ? CNT_W'(MAX_ZONES_Z)
                                                          : CNT_W'(zones_z_reg));
        ex = (CNT_W'(cur_x_reg) + CNT_W'(1)) >= nx;
        ey = (CNT_W'(cur_y_reg) + CNT_W'(1)) >= ny;
        ez = (CNT_W'(cur_z_reg) + CNT_W'(1)) >= nz;
    end

    // face stores
    logic [PA_W-1:0] plane_addr;
    logic [31:0]     line_rdata, plane_rdata;
    logic [31:0]     ox, oy, oz;

    assign plane_addr = PA_W'(int'(cur_y_reg) * MAX_ZONES_X + int'(cur_x_reg));

    ddsu_face_mem #(
        .LINE_D  (MAX_ZONES_X),
        .PLANE_D (PLANE_D),
        .LA_W    (IX_W),
        .PA_W    (PA_W)
    ) u_mem (
        .clk         (clk),
        .rd_en       (zone_acc),
        .wr_en       (load),
        .line_addr   (cur_x_reg),
        .plane_addr  (plane_addr),
        .line_wdata  (oy),
        .plane_wdata (oz),
        .line_rdata  (line_rdata),
        .plane_rdata (plane_rdata)
    );

    // coefficient dividers
    logic        coef_start;
    logic        cdone_x, cdone_y, cdone_z;
    logic [33:0] qx, qy, qz;

    assign coef_start = (state_reg == S_READ);

    ddsu_div #(.N(34), .D_W(31)) u_div_x (
        .clk (clk), .rst_n (rst_n), .start (coef_start), .rem_init ('0),
        .dividend_lo ({x_cos_reg, 17'd0}),
        .divisor ((wx_reg == '0) ? 31'd1 : wx_reg),
        .done (cdone_x), .quotient (qx)
    );

    ddsu_div #(.N(34), .D_W(31)) u_div_y (
        .clk (clk), .rst_n (rst_n), .start (coef_start), .rem_init ('0),
        .dividend_lo ({y_cos_reg, 17'd0}),
        .divisor ((wy_reg == '0) ? 31'd1 : wy_reg),
        .done (cdone_y), .quotient (qy)
    );

    ddsu_div #(.N(34), .D_W(31)) u_div_z (
        .clk (clk), .rst_n (rst_n), .start (coef_start), .rem_init ('0),
        .dividend_lo ({z_cos_reg, 17'd0}),
        .divisor ((wz_reg == '0) ? 31'd1 : wz_reg),
        .done (cdone_z), .quotient (qz)
    );

    // shared multiplier
    logic [COEF_W-1:0]  mul_a;
    logic signed [31:0] mul_b;
    logic signed [62:0] prod;

    always_comb
    begin
        case (mstep_reg)
            2'd0:    begin mul_a = cx_reg; mul_b = fl_reg; end
            2'd1:    begin mul_a = cy_reg; mul_b = ff_reg; end
            default: begin mul_a = cz_reg; mul_b = fb_reg; end
        endcase
        prod = $signed({1'b0, mul_a}) * mul_b;
    end

    // quotient divider
    logic [63:0] absnum;
    logic        ovf;
    logic        main_start;
    logic        mdone;
    logic [31:0] mq;

    always_comb
    begin
        absnum     = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
        ovf        = {1'b0, absnum[63:32]} >= den_reg;
        main_start = (state_reg == S_PREP) && (den_reg != '0) && !ovf;
    end

    ddsu_div #(.N(32), .D_W(DEN_W)) u_div_main (
        .clk (clk), .rst_n (rst_n), .start (main_start),
        .rem_init ({1'b0, absnum[63:32]}),
        .dividend_lo (absnum[31:0]),
        .divisor (den_reg),
        .done (mdone), .quotient (mq)
    );

    // outgoing faces
    always_comb
    begin
        ox = ddsu_pkg::sat34($signed({psi_reg[31], psi_reg, 1'b0})
                             - $signed({{2{fl_reg[31]}}, fl_reg}));
        oy = ddsu_pkg::sat34($signed({psi_reg[31], psi_reg, 1'b0})
                             - $signed({{2{ff_reg[31]}}, ff_reg}));
        oz = ddsu_pkg::sat34($signed({psi_reg[31], psi_reg, 1'b0})
                             - $signed({{2{fb_reg[31]}}, fb_reg}));
    end

    assign zone.ready = (state_reg == S_IDLE);
    assign zone_acc   = zone.valid && zone.ready;
    assign load       = (state_reg == S_FIN) && (!rv_reg || result.ready);
    assign cfg_hit    = cfg_we && (cfg_index <= ddsu_pkg::REG_Z_COS);

    // configuration, cursors, left face
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zones_x_reg <= 7'd1;
            zones_y_reg <= 7'd1;
            zones_z_reg <= 7'd1;
            x_cos_reg   <= 17'h10000;
            y_cos_reg   <= '0;
            z_cos_reg   <= '0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            cur_z_reg   <= '0;
            left_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ddsu_pkg::REG_ZONES_X: zones_x_reg <= cfg_data[6:0];
                    ddsu_pkg::REG_ZONES_Y: zones_y_reg <= cfg_data[6:0];
                    ddsu_pkg::REG_ZONES_Z: zones_z_reg <= cfg_data[6:0];
                    ddsu_pkg::REG_X_COS:   x_cos_reg   <= cfg_data;
                    ddsu_pkg::REG_Y_COS:   y_cos_reg   <= cfg_data;
                    ddsu_pkg::REG_Z_COS:   z_cos_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cfg_hit)
            begin
                cur_x_reg <= '0;
                cur_y_reg <= '0;
                cur_z_reg <= '0;
            end
            else if (load)
            begin
                left_reg <= ox;
                if (!ex)
                    cur_x_reg <= cur_x_reg + 1'b1;
                else
                begin
                    cur_x_reg <= '0;
                    if (!ey)
                        cur_y_reg <= cur_y_reg + 1'b1;
                    else
                    begin
                        cur_y_reg <= '0;
                        cur_z_reg <= ez ? '0 : cur_z_reg + 1'b1;
                    end
                end
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mstep_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (zone_acc) state_reg <= S_READ;
                S_READ: state_reg <= S_COEF;
                S_COEF:
                    if (cdone_x && cdone_y && cdone_z)
                    begin
                        mstep_reg <= '0;
                        state_reg <= S_MUL;
                    end
                S_MUL:
                begin
                    mstep_reg <= mstep_reg + 1'b1;
                    if (mstep_reg == 2'd2)
                        state_reg <= S_PREP;
                end
                S_PREP: state_reg <= main_start ? S_DIV : S_FIN;
                S_DIV:  if (mdone) state_reg <= S_FIN;
                S_FIN:  if (load) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (zone_acc)
        begin
            src_reg <= zone.source;
            sig_reg <= zone.sigma_total;
            wx_reg  <= zone.width_x;
            wy_reg  <= zone.width_y;
            wz_reg  <= zone.width_z;
            inx_reg <= zone.inflow_x;
            iny_reg <= zone.inflow_y;
            inz_reg <= zone.inflow_z;
        end
        if (state_reg == S_READ)
        begin
            fl_reg <= (cur_x_reg == '0) ? inx_reg : left_reg;
            ff_reg <= (cur_y_reg == '0) ? iny_reg : line_rdata;
            fb_reg <= (cur_z_reg == '0) ? inz_reg : plane_rdata;
        end
        if (state_reg == S_COEF && cdone_x && cdone_y && cdone_z)
        begin
            cx_reg  <= ddsu_pkg::coef_cap(qx);
            cy_reg  <= ddsu_pkg::coef_cap(qy);
            cz_reg  <= ddsu_pkg::coef_cap(qz);
            acc_reg <= {{16{src_reg[31]}}, src_reg, 16'd0};
        end
        if (state_reg == S_MUL)
        begin
            acc_reg <= acc_reg + 64'(prod);
            if (mstep_reg == 2'd0)
                den_reg <= DEN_W'(cx_reg) + DEN_W'(cy_reg) + DEN_W'(cz_reg)
                           + DEN_W'(sig_reg);
        end
        if (state_reg == S_PREP)
        begin
            if (den_reg == '0)
                psi_reg <= (acc_reg == '0) ? 32'd0 :
                           (acc_reg[63] ? ddsu_pkg::S32_MIN : ddsu_pkg::S32_MAX);
            else if (ovf)
                psi_reg <= acc_reg[63] ? ddsu_pkg::S32_MIN : ddsu_pkg::S32_MAX;
        end
        if (state_reg == S_DIV && mdone)
        begin
            if (acc_reg[63])
                psi_reg <= (mq > 32'h8000_0000) ? ddsu_pkg::S32_MIN : 32'(-mq);
            else
                psi_reg <= (mq > 32'h7FFF_FFFF) ? ddsu_pkg::S32_MAX : mq;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else if (load)
            rv_reg <= 1'b1;
        else if (result.ready)
            rv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            r_flux_reg <= psi_reg;
            r_ox_reg   <= ex ? ox : 32'd0;
            r_oy_reg   <= ey ? oy : 32'd0;
            r_oz_reg   <= ez ? oz : 32'd0;
            r_ex_reg   <= ex;
            r_ey_reg   <= ey;
            r_ez_reg   <= ez;
            r_done_reg <= ex && ey && ez;
        end
    end

    assign result.valid      = rv_reg;
    assign result.flux       = r_flux_reg;
    assign result.outflow_x  = r_ox_reg;
    assign result.outflow_y  = r_oy_reg;
    assign result.outflow_z  = r_oz_reg;
    assign result.at_exit_x  = r_ex_reg;
    assign result.at_exit_y  = r_ey_reg;
    assign result.at_exit_z  = r_ez_reg;
    assign result.sweep_done = r_done_reg;

    `DDSU_ASSERT_SAME(a_cur_x_in_range, 1'b1, CNT_W'(cur_x_reg) < nx)
    `DDSU_ASSERT_NEXT(a_div_to_fin, state_reg == S_DIV && mdone, state_reg == S_FIN)
    `DDSU_ASSERT_NEXT(a_load_sets_valid, load, result.valid && state_reg == S_IDLE)
endmodule

[rtl/ddsu_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsu_div
// Restoring divider, one quotient bit per cycle. rem_init must be below
// the divisor; quotient is valid while done is high.
// ----------------------------------------------------------------------------
module ddsu_div #(
    parameter int N   = 32,
    parameter int D_W = 33
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [D_W-1:0] rem_init,
    input  logic [N-1:0]   dividend_lo,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N-1:0]   quotient
);
    localparam int CW = $clog2(N + 1);

    logic [D_W-1:0] rem_reg;
    logic [N-1:0]   quo_reg;
    logic [D_W-1:0] dvs_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           ge;
    logic [D_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[N-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? diff[D_W-1:0] : trial[D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            quo_reg <= dividend_lo;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[N-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

[rtl/ddsu_face_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsu_face_mem
// Front line and bottom plane face stores with registered read.
// ----------------------------------------------------------------------------
module ddsu_face_mem #(
    parameter int LINE_D  = 64,
    parameter int PLANE_D = 4096,
    parameter int LA_W    = 6,
    parameter int PA_W    = 12
) (
    input  logic            clk,
    input  logic            rd_en,
    input  logic            wr_en,
    input  logic [LA_W-1:0] line_addr,
    input  logic [PA_W-1:0] plane_addr,
    input  logic [31:0]     line_wdata,
    input  logic [31:0]     plane_wdata,
    output logic [31:0]     line_rdata,
    output logic [31:0]     plane_rdata
);
    logic [31:0] line_mem  [LINE_D];
    logic [31:0] plane_mem [PLANE_D];
    logic [31:0] line_rd_reg;
    logic [31:0] plane_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[line_addr] <= line_wdata;
        if (rd_en)
            line_rd_reg <= line_mem[line_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            plane_mem[plane_addr] <= plane_wdata;
        if (rd_en)
            plane_rd_reg <= plane_mem[plane_addr];
    end

    assign line_rdata  = line_rd_reg;
    assign plane_rdata = plane_rd_reg;
endmodule
